// ----- design/pmf_pkg.sv -----
`default_nettype none

package pmf_pkg;

  // Largest pattern the block is built for; the chain holds twice as many bytes.
  localparam int DEFAULT_MAX_PATTERN = 8;

  // Widths fixed by the register and stream fields.
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 4;
  localparam int PAT_W     = 64;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTE = 2'd2;

  // Reset value of the replacement byte, an asterisk.
  localparam logic [BYTE_W-1:0] MASK_CHAR = 8'd42;

  // One byte held in the chain. A byte that is not done still belongs to the
  // search window; age counts the bytes accepted after it.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic              last;
    logic [LEN_W-1:0]  age;
    logic [BYTE_W-1:0] data;
  } pmf_slot_t;

  // Controls broadcast from the top level to every cell.
  typedef struct packed {
    logic              accept;
    logic              pop;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
    logic [LEN_W-1:0]  len;
    logic              zero_len;
    logic              full_window;
    logic [BYTE_W-1:0] repl_byte;
    logic [PAT_W-1:0]  pattern;
  } pmf_ctrl_t;

  // Pattern byte at a given position, first byte in the low bits.
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [PAT_W-1:0] pattern,
                                                     input logic [LEN_W-1:0] idx);
    return pattern[{idx[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

`default_nettype wire

// ----- design/pmf_cell.sv -----
`default_nettype none

module pmf_cell import pmf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire pmf_ctrl_t ctrl,
  input  wire logic      match,
  input  wire logic      is_tail,
  input  wire pmf_slot_t nbr,
  output pmf_slot_t      slot,
  output logic           win_ok
);

  pmf_slot_t        src;
  pmf_slot_t        slot_next;
  logic             pend;
  logic [LEN_W-1:0] age_n;
  logic             in_win_old;
  logic             in_win_new;
  logic             eq_old;
  logic             eq_new;

  always_comb begin
    // When the head leaves, every byte moves one cell toward the output.
    src        = ctrl.pop ? nbr : slot;
    pend       = src.valid & ~src.done;
    age_n      = src.age + LEN_W'(1);
    eq_old     = src.data == pattern_byte(ctrl.pattern, ctrl.len - age_n - LEN_W'(1));
    eq_new     = ctrl.in_byte == pattern_byte(ctrl.pattern, ctrl.len - LEN_W'(1));
    in_win_old = pend & (age_n < ctrl.len);
    in_win_new = ~ctrl.zero_len;

    win_ok = 1'b1;
    if (ctrl.accept) begin
      if (is_tail) begin
        win_ok = ~in_win_new | eq_new;
      end else begin
        win_ok = ~in_win_old | eq_old;
      end
    end

    slot_next = src;
    if (ctrl.accept && is_tail) begin
      slot_next.valid = 1'b1;
      slot_next.last  = ctrl.in_last;
      slot_next.age   = '0;
      slot_next.done  = ctrl.in_last | ctrl.zero_len |
                        (ctrl.full_window & (match | (LEN_W'(1) >= ctrl.len)));
      slot_next.data  = (match && in_win_new) ? ctrl.repl_byte : ctrl.in_byte;
    end else if (ctrl.accept && pend) begin
      slot_next.age  = age_n;
      slot_next.done = ctrl.in_last | ctrl.zero_len |
                       (ctrl.full_window & (match | ((age_n + LEN_W'(1)) >= ctrl.len)));
      slot_next.data = (match && in_win_old) ? ctrl.repl_byte : src.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot <= slot_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/pattern_mask_filter.sv -----
// Byte-stream search and replace.
// The input channel (in_valid, in_stall, in_byte, in_last) takes one byte per
// transfer; in_last marks the final byte of a stream. The output channel
// (out_valid, out_stall, out_byte, out_last) returns every byte once, in
// order, with each non-overlapping match of the pattern, found left to right,
// overwritten by the replacement byte. out_last rides on the final byte.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the
// user must do so only while the stream is idle, unchecked by the block.
// cfg_ready is always high. Throughput is one byte per cycle each way unless
// stalled, set by the single output register and the one-byte-per-cycle shift
// of the cell chain. A byte whose fate is known on arrival passes its cell and
// the output register; a byte that may start a match waits until enough later
// bytes have arrived to settle it, or until in_last flushes the window.
// The chain holds 2*MAX_PATTERN bytes; in_stall rises only when every cell is
// occupied, which happens only when the receiver holds out_stall for long.
// A stalled output keeps its byte; decided bytes queue in the chain behind it.
// Reset empties the chain and the output register, sets the pattern length
// to zero (pass-through) and the replacement byte to an asterisk.
`default_nettype none

module pattern_mask_filter import pmf_pkg::*; #(
  parameter int MAX_PATTERN = DEFAULT_MAX_PATTERN
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_byte,
  input  wire logic                 in_last,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         out_byte,
  output logic                      out_last,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAT_W-1:0]     cfg_data
);

  localparam int DEPTH = 2 * MAX_PATTERN;
  localparam int CW    = $clog2(DEPTH + 1);

  // Configuration registers.
  logic [PAT_W-1:0]  pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic [BYTE_W-1:0] replacement_byte;

  // Chain occupancy and the number of bytes still in the search window.
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     cnt_next;
  logic [LEN_W-1:0]  pend_cnt;
  logic [LEN_W-1:0]  pend_cnt_next;

  logic [LEN_W-1:0]  len;
  logic              accept;
  logic              pop;
  logic              out_free;
  logic              match;
  logic [CW-1:0]     tail_pos;
  pmf_ctrl_t         ctrl;

  pmf_slot_t         slots [DEPTH];
  logic [DEPTH-1:0]  win_ok;
  logic [DEPTH-1:0]  tail;
  logic [DEPTH-1:0]  valid_vec;
  logic [DEPTH-1:0]  pend_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes    <= '0;
      pattern_length   <= '0;
      replacement_byte <= MASK_CHAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:    pattern_bytes    <= cfg_data;
        CFG_PATTERN_LENGTH:   pattern_length   <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTE: replacement_byte <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // A length above what the chain is built for saturates.
  assign len = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pattern_length;

  assign in_stall = (cnt == CW'(DEPTH));
  assign accept   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign pop      = slots[0].valid & slots[0].done & out_free;
  assign tail_pos = cnt - CW'(pop);

  always_comb begin
    ctrl.accept      = accept;
    ctrl.pop         = pop;
    ctrl.in_byte     = in_byte;
    ctrl.in_last     = in_last;
    ctrl.len         = len;
    ctrl.zero_len    = (len == '0);
    ctrl.full_window = (pend_cnt + LEN_W'(1)) >= len;
    ctrl.repl_byte   = replacement_byte;
    ctrl.pattern     = pattern_bytes;
  end

  // A match needs a full window whose every byte agrees with the pattern.
  assign match = accept & ~ctrl.zero_len & ctrl.full_window & (&win_ok);

  genvar k;
  for (k = 0; k < DEPTH; k++) begin : g_cell
    pmf_slot_t nbr;

    if (k == DEPTH - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = slots[k+1];
    end

    assign tail[k]      = (tail_pos == CW'(k));
    assign valid_vec[k] = slots[k].valid;
    assign pend_vec[k]  = slots[k].valid & ~slots[k].done;

    pmf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .match   (match),
      .is_tail (tail[k]),
      .nbr     (nbr),
      .slot    (slots[k]),
      .win_ok  (win_ok[k])
    );
  end

  // The window empties on a match, on the last byte or with a zero length;
  // otherwise a full window keeps its newest length-minus-one bytes.
  always_comb begin
    cnt_next      = cnt - CW'(pop) + CW'(accept);
    pend_cnt_next = pend_cnt;
    if (accept) begin
      priority if (in_last || ctrl.zero_len || match) begin
        pend_cnt_next = '0;
      end else if (ctrl.full_window) begin
        pend_cnt_next = len - LEN_W'(1);
      end else begin
        pend_cnt_next = pend_cnt + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      pend_cnt <= '0;
    end else begin
      cnt      <= cnt_next;
      pend_cnt <= pend_cnt_next;
    end
  end

  // Output register: loaded from the head cell whenever it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte <= slots[0].data;
      out_last <= slots[0].last;
    end
  end

  // The window counter agrees with the bytes the cells hold as undecided.
  a_pend_count : assert property (@(posedge clk) disable iff (rst)
    $countones(pend_vec) == int'(pend_cnt))
    else $error("window count differs from undecided cells");

  // The occupancy counter agrees with the occupied cells.
  a_occupancy : assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(cnt))
    else $error("occupancy count differs from occupied cells");

  // Occupied cells form an unbroken run from the head.
  a_packed : assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("gap in the cell chain");

endmodule

`default_nettype wire
